// ===== rtl/core/ssab_pkg.sv =====
// ----------------------------------------------------------------------------
// ssab_pkg : shared types and constants of the scaled sprite blit unit
// Register map, item formats passed from front to back, and fixed sizes.
// ----------------------------------------------------------------------------
package ssab_pkg;

   // Size limits of the dimension registers
   localparam int ICON_MAX_DIM = 64;
   localparam int DEST_MAX_DIM = 4096;

   // Icon pixel store
   localparam int STORE_DEPTH = 4096;
   localparam int STORE_AW    = 12;

   // Scaling divider: numerator offset*icon_dim, quotient below ICON_MAX_DIM
   localparam int NUM_W  = 19;
   localparam int REM_W  = NUM_W + 1;
   localparam int QUOT_W = (ICON_MAX_DIM > 1) ? $clog2(ICON_MAX_DIM) : 1;

   // Blend constants
   localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
   localparam logic [31:0] OPAQUE_MASK  = 32'hff000000;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_ICON_WIDTH   = 3'd0,
      CSR_ICON_HEIGHT  = 3'd1,
      CSR_DEST_WIDTH   = 3'd2,
      CSR_DEST_HEIGHT  = 3'd3,
      CSR_ORIGIN_X     = 3'd4,
      CSR_ORIGIN_Y     = 3'd5,
      CSR_FRAME_WIDTH  = 3'd6,
      CSR_FRAME_HEIGHT = 3'd7
   } ssab_csr_type;

   // Configuration register set
   typedef struct packed {
      logic [6:0]         icon_width;
      logic [6:0]         icon_height;
      logic [12:0]        dest_width;
      logic [12:0]        dest_height;
      logic signed [12:0] origin_x;
      logic signed [12:0] origin_y;
      logic [12:0]        frame_width;
      logic [12:0]        frame_height;
   } ssab_cfg_type;

   localparam ssab_cfg_type CFG_RESET = '{
      icon_width:   7'd1,
      icon_height:  7'd1,
      dest_width:   13'd1,
      dest_height:  13'd1,
      origin_x:     13'sd0,
      origin_y:     13'sd0,
      frame_width:  13'd1,
      frame_height: 13'd1
   };

   // Classified item from the front end
   typedef struct packed {
      logic              is_write;
      logic              is_load;
      logic [11:0]       slot;
      logic [31:0]       argb;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic [12:0]       px;
      logic [12:0]       py;
   } ssab_item_type;

   // Item inside the divider stages
   typedef struct packed {
      logic              is_write;
      logic              is_load;
      logic [11:0]       slot;
      logic [31:0]       argb;
      logic [NUM_W-1:0]  rem_x;
      logic [NUM_W-1:0]  rem_y;
      logic [QUOT_W-1:0] quot_x;
      logic [QUOT_W-1:0] quot_y;
      logic [12:0]       px;
      logic [12:0]       py;
   } ssab_div_type;

endpackage

// ===== rtl/core/ssab_ram.sv =====
// ----------------------------------------------------------------------------
// ssab_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssab_front.sv =====
// ----------------------------------------------------------------------------
// ssab_front : input stage of the blit unit
// Takes request transfers, checks rectangle and clip, forms the scaling
// numerators and the framebuffer point, and hands the item to the queue.
// ----------------------------------------------------------------------------
module ssab_front (
   input  logic                   clock,
   input  logic                   reset,
   input  ssab_pkg::ssab_cfg_type cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [11:0]            req_icon_slot,
   input  logic [31:0]            req_icon_argb,
   input  logic [11:0]            req_offset_x,
   input  logic [11:0]            req_offset_y,
   input  logic [31:0]            req_dest_argb,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ssab_pkg::ssab_item_type out_item
);

   localparam logic [7:0]  ICON_LIMIT = 8'(ssab_pkg::ICON_MAX_DIM);
   localparam logic [13:0] DEST_LIMIT = 14'(ssab_pkg::DEST_MAX_DIM);

   logic                   f_valid_ff, f_valid_in;
   ssab_pkg::ssab_item_type f_item_ff, f_item_in;

   logic               dims_ok, in_rect, x_ok, y_ok, req_fire;
   logic signed [13:0] px_full, py_full;

   assign req_ready = !f_valid_ff || out_ready;
   assign req_fire  = req_valid && req_ready;

   // dimension registers within range
   assign dims_ok = (cfg.icon_width  != 7'd0) && ({1'b0, cfg.icon_width}  <= ICON_LIMIT) &&
                    (cfg.icon_height != 7'd0) && ({1'b0, cfg.icon_height} <= ICON_LIMIT) &&
                    (cfg.dest_width  != 13'd0) && ({1'b0, cfg.dest_width}  <= DEST_LIMIT) &&
                    (cfg.dest_height != 13'd0) && ({1'b0, cfg.dest_height} <= DEST_LIMIT);

   assign in_rect = ({1'b0, req_offset_x} < cfg.dest_width) &&
                    ({1'b0, req_offset_y} < cfg.dest_height);

   // framebuffer point and clip
   assign px_full = 14'(cfg.origin_x) + $signed({2'b00, req_offset_x});
   assign py_full = 14'(cfg.origin_y) + $signed({2'b00, req_offset_y});
   assign x_ok    = !px_full[13] && (px_full[12:0] < cfg.frame_width);
   assign y_ok    = !py_full[13] && (py_full[12:0] < cfg.frame_height);

   // classify and build the item
   always_comb begin
      f_item_in.is_write = (req_cmd == ssab_pkg::CMD_DRAW) && dims_ok && in_rect && x_ok && y_ok;
      f_item_in.is_load  = (req_cmd == ssab_pkg::CMD_LOAD);
      f_item_in.slot     = req_icon_slot;
      f_item_in.argb     = (req_cmd == ssab_pkg::CMD_LOAD) ? req_icon_argb : req_dest_argb;
      f_item_in.num_x    = ssab_pkg::NUM_W'(req_offset_x) * ssab_pkg::NUM_W'(cfg.icon_width);
      f_item_in.num_y    = ssab_pkg::NUM_W'(req_offset_y) * ssab_pkg::NUM_W'(cfg.icon_height);
      f_item_in.px       = px_full[12:0];
      f_item_in.py       = py_full[12:0];
   end

   always_comb begin
      f_valid_in = f_valid_ff;
      if (req_fire) begin
         f_valid_in = 1'b1;
      end else if (out_ready) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         f_item_ff <= f_item_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_item  = f_item_ff;

endmodule

// ===== rtl/core/ssab_queue.sv =====
// ----------------------------------------------------------------------------
// ssab_queue : short item queue between front and back
// Register FIFO; lets each side stall without holding up the other.
// ----------------------------------------------------------------------------
module ssab_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  ssab_pkg::ssab_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output ssab_pkg::ssab_item_type pop_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   ssab_pkg::ssab_item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/ssab_back.sv =====
// ----------------------------------------------------------------------------
// ssab_back : execution pipeline of the blit unit
// Pipelined scaling divider, icon store access, alpha blend and the
// response register. The whole pipeline holds while the response stalls.
// ----------------------------------------------------------------------------
module ssab_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ssab_pkg::ssab_cfg_type  cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ssab_pkg::ssab_item_type in_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_write_valid,
   output logic [23:0]             rsp_frame_address,
   output logic [31:0]             rsp_blended_argb
);

   localparam int QW = ssab_pkg::QUOT_W;

   // address stage
   typedef struct packed {
      logic        is_write;
      logic        is_load;
      logic [31:0] argb;
      logic [11:0] index;
      logic [25:0] row_base;
      logic [12:0] px;
   } ssab_addr_type;

   // store read stage
   typedef struct packed {
      logic        is_write;
      logic [31:0] dst;
      logic [23:0] addr;
   } ssab_read_type;

   // blend product stage
   typedef struct packed {
      logic             is_write;
      logic [23:0]      addr;
      logic [31:0]      dst;
      logic [31:0]      src;
      logic [2:0][15:0] prod_s;
      logic [2:0][15:0] prod_d;
   } ssab_mix_type;

   logic                   en;
   logic [QW:0]            sv_ff, sv_in;
   ssab_pkg::ssab_div_type s_ff [QW+1];
   ssab_pkg::ssab_div_type s_in [QW+1];
   logic                   a_v_ff, r_v_ff, m_v_ff;
   ssab_addr_type          a_ff, a_in;
   ssab_read_type          r_ff, r_in;
   ssab_mix_type           m_ff, m_in;
   logic [31:0]            src_word;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_write_ff, rsp_write_in;
   logic [23:0]            rsp_addr_ff, rsp_addr_in;
   logic [31:0]            rsp_argb_ff, rsp_argb_in;

   // pipeline advances unless a finished response is held
   assign en       = !rsp_valid_ff || rsp_ready;
   assign in_ready = en;

   // divider: one quotient bit per stage, both axes side by side
   always_comb begin
      logic [ssab_pkg::REM_W-1:0] sh_x;
      logic [ssab_pkg::REM_W-1:0] sh_y;
      s_in[0].is_write = in_item.is_write;
      s_in[0].is_load  = in_item.is_load;
      s_in[0].slot     = in_item.slot;
      s_in[0].argb     = in_item.argb;
      s_in[0].rem_x    = in_item.num_x;
      s_in[0].rem_y    = in_item.num_y;
      s_in[0].quot_x   = '0;
      s_in[0].quot_y   = '0;
      s_in[0].px       = in_item.px;
      s_in[0].py       = in_item.py;
      for (int k = 0; k < QW; k++) begin
         sh_x = ssab_pkg::REM_W'(cfg.dest_width) << (QW - 1 - k);
         sh_y = ssab_pkg::REM_W'(cfg.dest_height) << (QW - 1 - k);
         s_in[k+1] = s_ff[k];
         if ({1'b0, s_ff[k].rem_x} >= sh_x) begin
            s_in[k+1].rem_x             = s_ff[k].rem_x - sh_x[ssab_pkg::NUM_W-1:0];
            s_in[k+1].quot_x[QW-1-k]    = 1'b1;
         end
         if ({1'b0, s_ff[k].rem_y} >= sh_y) begin
            s_in[k+1].rem_y             = s_ff[k].rem_y - sh_y[ssab_pkg::NUM_W-1:0];
            s_in[k+1].quot_y[QW-1-k]    = 1'b1;
         end
      end
   end

   assign sv_in = {sv_ff[QW-1:0], in_valid};

   // icon index and framebuffer row base
   always_comb begin
      logic [12:0] idx_full;
      idx_full = 13'(s_ff[QW].quot_y) * 13'(cfg.icon_width) + 13'(s_ff[QW].quot_x);
      a_in.is_write = s_ff[QW].is_write;
      a_in.is_load  = s_ff[QW].is_load;
      a_in.argb     = s_ff[QW].argb;
      a_in.index    = s_ff[QW].is_load ? s_ff[QW].slot : idx_full[11:0];
      a_in.row_base = 26'(s_ff[QW].py) * 26'(cfg.frame_width);
      a_in.px       = s_ff[QW].px;
   end

   // icon store: loads write, draws read, both at the same stage
   ssab_ram #(
      .WIDTH (32),
      .DEPTH (ssab_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (en && a_v_ff && a_ff.is_load),
      .wr_addr (a_ff.index),
      .wr_data (a_ff.argb),
      .rd_en   (en),
      .rd_addr (a_ff.index),
      .rd_data (src_word)
   );

   always_comb begin
      logic [25:0] addr_full;
      addr_full     = a_ff.row_base + 26'(a_ff.px);
      r_in.is_write = a_ff.is_write;
      r_in.dst      = a_ff.argb;
      r_in.addr     = addr_full[23:0];
   end

   // per-channel blend products
   always_comb begin
      logic [7:0] alpha;
      alpha         = src_word[31:24];
      m_in.is_write = r_ff.is_write;
      m_in.addr     = r_ff.addr;
      m_in.dst      = r_ff.dst;
      m_in.src      = src_word;
      for (int c = 0; c < 3; c++) begin
         m_in.prod_s[c] = 16'(src_word[8*c +: 8]) * 16'(alpha);
         m_in.prod_d[c] = 16'(r_ff.dst[8*c +: 8]) * 16'(ssab_pkg::ALPHA_OPAQUE - alpha);
      end
   end

   // sum, divide by 255, pick the special alpha cases
   always_comb begin
      logic [16:0] sum;
      logic [16:0] scaled;
      logic [31:0] mixed;
      mixed = ssab_pkg::OPAQUE_MASK;
      for (int c = 0; c < 3; c++) begin
         sum    = 17'(m_ff.prod_s[c]) + 17'(m_ff.prod_d[c]);
         scaled = sum + 17'(sum[16:8]) + 17'd1;
         mixed[8*c +: 8] = scaled[15:8];
      end
      rsp_write_in = m_ff.is_write;
      rsp_addr_in  = m_ff.is_write ? m_ff.addr : '0;
      if (!m_ff.is_write) begin
         rsp_argb_in = '0;
      end else if (m_ff.src[31:24] == ssab_pkg::ALPHA_CLEAR) begin
         rsp_argb_in = m_ff.dst;
      end else if (m_ff.src[31:24] == ssab_pkg::ALPHA_OPAQUE) begin
         rsp_argb_in = m_ff.src;
      end else begin
         rsp_argb_in = mixed;
      end
      rsp_valid_in = en ? m_v_ff : rsp_valid_ff;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff        <= '0;
         a_v_ff       <= 1'b0;
         r_v_ff       <= 1'b0;
         m_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (en) begin
            sv_ff  <= sv_in;
            a_v_ff <= sv_ff[QW];
            r_v_ff <= a_v_ff;
            m_v_ff <= r_v_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QW; k++) begin
            s_ff[k] <= s_in[k];
         end
         a_ff         <= a_in;
         r_ff         <= r_in;
         m_ff         <= m_in;
         rsp_write_ff <= rsp_write_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_argb_ff  <= rsp_argb_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_write_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_blended_argb  = rsp_argb_ff;

endmodule

// ===== rtl/core/scaled_sprite_alpha_blit_unit.sv =====
// ----------------------------------------------------------------------------
// scaled_sprite_alpha_blit_unit : nearest-neighbour scaled icon blit
// Icon pixel store, scaling, clipping and alpha blend into a pixel stream.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one transfer per item. Load (cmd 0) writes req_icon_argb into
//            the icon store at req_icon_slot. Draw (cmd 1) maps the offset
//            to an icon pixel, clips it and blends it over req_dest_argb.
//   rsp_*  : exactly one transfer per request, in request order. Loads,
//            out-of-rectangle and clipped points return write_valid 0 with
//            zero address and pixel.
//   csr_*  : register writes, always accepted; write only while idle.
// Throughput: one item per clock, sustained while every response is taken,
//   in any mix of loads and draws. Path from request to response: an input
//   register, the queue, the divider input register, six divider stages (one
//   quotient bit each for x and y), the index/row multiply, the store read,
//   the blend products and the response register.
// Stall: a held response freezes the execution pipeline; the queue keeps
//   taking requests until it fills, then req_ready drops.
// Reset: pipeline and queue empty, registers to their reset values; the
//   icon store is undefined until loaded.
// ----------------------------------------------------------------------------
module scaled_sprite_alpha_blit_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [11:0] req_icon_slot,
   input  logic [31:0] req_icon_argb,
   input  logic [11:0] req_offset_x,
   input  logic [11:0] req_offset_y,
   input  logic [31:0] req_dest_argb,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_valid,
   output logic [23:0] rsp_frame_address,
   output logic [31:0] rsp_blended_argb,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   ssab_pkg::ssab_cfg_type  cfg_ff, cfg_in;
   ssab_pkg::ssab_item_type f_item, q_item;
   logic                    f_valid, f_ready, q_valid, q_ready;

   assign csr_ready = 1'b1;

   // configuration registers, low bits of the written word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (ssab_pkg::ssab_csr_type'(csr_index))
            ssab_pkg::CSR_ICON_WIDTH:   cfg_in.icon_width   = csr_wdata[6:0];
            ssab_pkg::CSR_ICON_HEIGHT:  cfg_in.icon_height  = csr_wdata[6:0];
            ssab_pkg::CSR_DEST_WIDTH:   cfg_in.dest_width   = csr_wdata[12:0];
            ssab_pkg::CSR_DEST_HEIGHT:  cfg_in.dest_height  = csr_wdata[12:0];
            ssab_pkg::CSR_ORIGIN_X:     cfg_in.origin_x     = $signed(csr_wdata[12:0]);
            ssab_pkg::CSR_ORIGIN_Y:     cfg_in.origin_y     = $signed(csr_wdata[12:0]);
            ssab_pkg::CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[12:0];
            ssab_pkg::CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[12:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ssab_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssab_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_icon_slot (req_icon_slot),
      .req_icon_argb (req_icon_argb),
      .req_offset_x  (req_offset_x),
      .req_offset_y  (req_offset_y),
      .req_dest_argb (req_dest_argb),
      .out_valid     (f_valid),
      .out_ready     (f_ready),
      .out_item      (f_item)
   );

   ssab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   ssab_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .in_valid          (q_valid),
      .in_ready          (q_ready),
      .in_item           (q_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_frame_address (rsp_frame_address),
      .rsp_blended_argb  (rsp_blended_argb)
   );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb : self-checking bench for scaled_sprite_alpha_blit_unit
// Drives load and draw items with bursty gaps against a receiver that stalls
// in changing patterns. A behavioural copy of the scaling, clipping and blend
// path predicts the responses not typed into the directed rows, and each one
// is compared in order. Register settings are changed between phases while
// the pipeline is empty, from corner settings first and random ones after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ssab_pkg::*;

   localparam int RANDOM_ITEMS = 1950;
   localparam int DIRECTED_N   = 20;
   localparam int EXTREME_N    = 13;

   // One item of the request channel
   typedef struct packed {
      logic        cmd;
      logic [11:0] slot;
      logic [31:0] icon_argb;
      logic [11:0] off_x;
      logic [11:0] off_y;
      logic [31:0] dest_argb;
   } blit_req_t;

   // One framebuffer write as returned on the response channel
   typedef struct packed {
      logic        wr;
      logic [23:0] addr;
      logic [31:0] argb;
   } fb_write_t;

   // Directed row: request, then an optional typed-in response
   typedef struct packed {
      logic        cmd;
      logic [11:0] slot;
      logic [31:0] icon_argb;
      logic [11:0] off_x;
      logic [11:0] off_y;
      logic [31:0] dest_argb;
      logic        typed;
      logic        wr;
      logic [23:0] addr;
      logic [31:0] argb;
   } blit_vec_t;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_RANDOM,
      DRAIN_SPARSE,
      DRAIN_STALLS
   } drain_mode_t;

   // Directed rows, all under the reset register values (1x1 everything)
   localparam blit_vec_t DIRECTED_ROWS [DIRECTED_N] = '{
      // transparent pixel keeps the framebuffer value
      '{CMD_LOAD, 12'h000, 32'h0, 12'h0, 12'h0, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h0, 12'h0, 32'hffffffff, 1'b1, 1'b1, 24'h0, 32'hffffffff},
      // opaque pixel replaces it; draw fields of a load are don't-care
      '{CMD_LOAD, 12'h000, 32'hffffffff, 12'hfff, 12'hfff, 32'hffffffff,
        1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h0, 12'h0, 32'h0, 1'b1, 1'b1, 24'h0, 32'hffffffff},
      '{CMD_LOAD, 12'hfff, 32'h12345678, 12'h0, 12'h0, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      // half alpha blend
      '{CMD_LOAD, 12'h000, 32'h80ff8000, 12'h0, 12'h0, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h0, 12'h0, 32'h00336699, 1'b0, 1'b0, 24'h0, 32'h0},
      // offsets outside the rectangle
      '{CMD_DRAW, 12'h0, 32'h0, 12'hfff, 12'h0, 32'hffffffff, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h0, 12'hfff, 32'hffffffff, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'hfff, 12'hfff, 32'h5a5a5a5a, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h001, 12'h0, 32'h12345678, 1'b1, 1'b0, 24'h0, 32'h0},
      // alpha just above clear and just below opaque
      '{CMD_LOAD, 12'h000, 32'h01abcdef, 12'h0, 12'h0, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h0, 12'h0, 32'hfe123456, 1'b0, 1'b0, 24'h0, 32'h0},
      '{CMD_LOAD, 12'h000, 32'hfe00ff80, 12'h0, 12'h0, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h0, 12'h0, 32'h00ff007f, 1'b0, 1'b0, 24'h0, 32'h0},
      // alternating bit patterns on slot and pixel
      '{CMD_LOAD, 12'haaa, 32'h55555555, 12'h555, 12'haaa, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_LOAD, 12'h555, 32'haaaaaaaa, 12'haaa, 12'h555, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      // load fields of a draw are don't-care
      '{CMD_DRAW, 12'hfff, 32'hffffffff, 12'h0, 12'h0, 32'ha5a5a5a5, 1'b0, 1'b0, 24'h0, 32'h0},
      '{CMD_LOAD, 12'h000, 32'h7f808080, 12'h0, 12'h0, 32'h0, 1'b1, 1'b0, 24'h0, 32'h0},
      '{CMD_DRAW, 12'h0, 32'h0, 12'h0, 12'h0, 32'h80808080, 1'b0, 1'b0, 24'h0, 32'h0}
   };

   // Corner register settings, one per opening phase:
   // icon w/h, dest w/h, origin x/y, frame w/h
   localparam ssab_cfg_type EXTREME_CFGS [EXTREME_N] = '{
      '{7'd64, 7'd64, 13'd4096, 13'd4096, 13'h0000, 13'h0000, 13'd4096, 13'd4096},
      // far corner, address wider than 24 bits
      '{7'd64, 7'd64, 13'd4096, 13'd4096, 13'h0fff, 13'h0fff, 13'd8191, 13'd8191},
      // most negative origin, everything clipped
      '{7'd64, 7'd1, 13'd64, 13'd1, 13'h1000, 13'h0000, 13'd4096, 13'd1},
      // illegal dimensions
      '{7'd0, 7'd8, 13'd16, 13'd16, 13'h0000, 13'h0000, 13'd16, 13'd16},
      '{7'd127, 7'd64, 13'd64, 13'd64, 13'h0000, 13'h0000, 13'd64, 13'd64},
      '{7'd8, 7'd8, 13'd0, 13'd16, 13'h0000, 13'h0000, 13'd16, 13'd16},
      '{7'd8, 7'd8, 13'd16, 13'd8191, 13'h0000, 13'h0000, 13'd16, 13'd16},
      '{7'd65, 7'd65, 13'd4097, 13'd4097, 13'h0000, 13'h0000, 13'd4096, 13'd4096},
      // zero frame size
      '{7'd8, 7'd8, 13'd16, 13'd16, 13'h0000, 13'h0000, 13'd0, 13'd8191},
      '{7'd8, 7'd8, 13'd16, 13'd16, 13'h0000, 13'h0000, 13'd16, 13'd0},
      // strongest shrink and strongest stretch
      '{7'd64, 7'd64, 13'd1, 13'd1, 13'h0000, 13'h0000, 13'd1, 13'd1},
      '{7'd1, 7'd1, 13'd4096, 13'd4096, 13'h1800, 13'h1800, 13'd4096, 13'd4096},
      // rectangle hanging over every frame edge
      '{7'd16, 7'd16, 13'd32, 13'd32, 13'h1ff8, 13'h1ff8, 13'd16, 13'd16}
   };

   logic        clock;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic        req_cmd           = CMD_LOAD;
   logic [11:0] req_icon_slot     = '0;
   logic [31:0] req_icon_argb     = '0;
   logic [11:0] req_offset_x      = '0;
   logic [11:0] req_offset_y      = '0;
   logic [31:0] req_dest_argb     = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic        rsp_write_valid;
   logic [23:0] rsp_frame_address;
   logic [31:0] rsp_blended_argb;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index         = '0;
   logic [31:0] csr_wdata         = '0;

   // Shadow of the block: registers and icon store
   ssab_cfg_type cfg_shadow = CFG_RESET;
   logic [31:0]  icon_mirror [STORE_DEPTH];
   bit           icon_loaded [STORE_DEPTH];

   fb_write_t    fb_write_q [$];
   int           mismatches  = 0;
   int           items_sent  = 0;
   int           burst_left  = 0;
   bit           quiet_phase = 1'b0;
   drain_mode_t  drain_mode  = DRAIN_FREE;
   int           mode_left   = 0;
   int           hold_left   = 0;

   scaled_sprite_alpha_blit_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_icon_slot     (req_icon_slot),
      .req_icon_argb     (req_icon_argb),
      .req_offset_x      (req_offset_x),
      .req_offset_y      (req_offset_y),
      .req_dest_argb     (req_dest_argb),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_frame_address (rsp_frame_address),
      .rsp_blended_argb  (rsp_blended_argb),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Scaling and clipping of one draw offset; tells whether it writes,
   // and if so which icon entry it reads and where it lands
   function automatic bit sprite_hit(input logic [11:0] ox, input logic [11:0] oy,
                                     output logic [11:0] idx, output logic [23:0] addr);
      int     iw, ih, dw, dh, px, py;
      longint lin;
      iw   = int'(cfg_shadow.icon_width);
      ih   = int'(cfg_shadow.icon_height);
      dw   = int'(cfg_shadow.dest_width);
      dh   = int'(cfg_shadow.dest_height);
      idx  = '0;
      addr = '0;
      if (iw == 0 || iw > ICON_MAX_DIM || ih == 0 || ih > ICON_MAX_DIM ||
          dw == 0 || dw > DEST_MAX_DIM || dh == 0 || dh > DEST_MAX_DIM)
         return 1'b0;
      if (int'(ox) >= dw || int'(oy) >= dh)
         return 1'b0;
      px = int'($signed(cfg_shadow.origin_x)) + int'(ox);
      py = int'($signed(cfg_shadow.origin_y)) + int'(oy);
      if (px < 0 || py < 0 || px >= int'(cfg_shadow.frame_width) ||
          py >= int'(cfg_shadow.frame_height))
         return 1'b0;
      idx  = 12'((int'(oy) * ih / dh) * iw + int'(ox) * iw / dw);
      lin  = longint'(py) * longint'(cfg_shadow.frame_width) + longint'(px);
      addr = 24'(lin);
      return 1'b1;
   endfunction

   // Icon pixel with alpha biased towards clear and opaque
   function automatic logic [31:0] rand_icon_pixel();
      logic [31:0] p;
      p = $urandom();
      case ($urandom_range(0, 3))
         0: p[31:24] = ALPHA_CLEAR;
         1: p[31:24] = ALPHA_OPAQUE;
         default: ;
      endcase
      return p;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
   endtask

   // Sender bursts: drop valid for a random gap between bursts
   task automatic pace_sender();
      int gap;
      if (!quiet_phase) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
   endtask

   // Present one item, wait for its transfer, then queue the expected write.
   // Valid is left high so a following item can go out back to back.
   task automatic send_req(input blit_req_t r, input bit typed, input fb_write_t typed_w);
      fb_write_t   w;
      logic [11:0] idx;
      logic [23:0] addr;
      logic [31:0] src;
      int          a;
      req_valid     <= 1'b1;
      req_cmd       <= r.cmd;
      req_icon_slot <= r.slot;
      req_icon_argb <= r.icon_argb;
      req_offset_x  <= r.off_x;
      req_offset_y  <= r.off_y;
      req_dest_argb <= r.dest_argb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;

      // expected response: loads fill the store, draws blend over the frame
      w = '0;
      if (r.cmd == CMD_LOAD) begin
         icon_mirror[r.slot] = r.icon_argb;
         icon_loaded[r.slot] = 1'b1;
      end else if (sprite_hit(r.off_x, r.off_y, idx, addr)) begin
         src    = icon_mirror[idx];
         a      = int'(src[31:24]);
         w.wr   = 1'b1;
         w.addr = addr;
         if (src[31:24] == ALPHA_CLEAR)
            w.argb = r.dest_argb;
         else if (src[31:24] == ALPHA_OPAQUE)
            w.argb = src;
         else begin
            w.argb = OPAQUE_MASK;
            for (int c = 0; c < 3; c++)
               w.argb[8*c +: 8] = 8'((int'(src[8*c +: 8]) * a +
                                      int'(r.dest_argb[8*c +: 8]) * (255 - a)) / 255);
         end
      end
      fb_write_q.push_back(typed ? typed_w : w);
   endtask

   // Stimulus
   initial begin
      blit_req_t    r;
      blit_req_t    ld;
      blit_vec_t    row;
      fb_write_t    tw;
      ssab_cfg_type c;
      ssab_csr_type ridx;
      logic [95:0]  noise;
      logic [31:0]  val;
      logic [11:0]  idx;
      logic [23:0]  addr;
      int           lim_x, lim_y, pick, n, phase;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows under the reset register values
      for (int i = 0; i < DIRECTED_N; i++) begin
         row = DIRECTED_ROWS[i];
         r   = '{row.cmd, row.slot, row.icon_argb, row.off_x, row.off_y, row.dest_argb};
         tw  = '{row.wr, row.addr, row.argb};
         pace_sender();
         send_req(r, row.typed, tw);
      end
      req_valid <= 1'b0;

      phase = 0;
      while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
         // registers change only with the pipeline empty
         while (fb_write_q.size() != 0) @(posedge clock);

         if (phase < EXTREME_N)
            c = EXTREME_CFGS[phase];
         else begin
            c.icon_width  = 7'($urandom_range(1, ICON_MAX_DIM));
            c.icon_height = 7'($urandom_range(1, ICON_MAX_DIM));
            c.dest_width  = 13'(($urandom_range(0, 7) == 0) ?
                                $urandom_range(1, DEST_MAX_DIM) : $urandom_range(1, 96));
            c.dest_height = 13'(($urandom_range(0, 7) == 0) ?
                                $urandom_range(1, DEST_MAX_DIM) : $urandom_range(1, 96));
            c.origin_x     = 13'(int'($urandom_range(0, 48)) - 16);
            c.origin_y     = 13'(int'($urandom_range(0, 48)) - 16);
            c.frame_width  = 13'($urandom_range(1, int'(c.dest_width) + 32));
            c.frame_height = 13'($urandom_range(1, int'(c.dest_height) + 32));
            if ($urandom_range(0, 15) == 0) begin
               noise = {$urandom(), $urandom(), $urandom()};
               c     = noise[$bits(ssab_cfg_type)-1:0];
            end
         end

         // write every register, with junk above the used bits at times
         ridx = ridx.first();
         do begin
            val = ($urandom_range(0, 1) != 0) ? $urandom() : 32'h0;
            case (ridx)
               CSR_ICON_WIDTH:   val[6:0]  = c.icon_width;
               CSR_ICON_HEIGHT:  val[6:0]  = c.icon_height;
               CSR_DEST_WIDTH:   val[12:0] = c.dest_width;
               CSR_DEST_HEIGHT:  val[12:0] = c.dest_height;
               CSR_ORIGIN_X:     val[12:0] = c.origin_x;
               CSR_ORIGIN_Y:     val[12:0] = c.origin_y;
               CSR_FRAME_WIDTH:  val[12:0] = c.frame_width;
               CSR_FRAME_HEIGHT: val[12:0] = c.frame_height;
               default: ;
            endcase
            csr_valid <= 1'b1;
            csr_index <= ridx;
            csr_wdata <= val;
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            ridx = ridx.next();
         end while (ridx != ridx.first());
         csr_valid <= 1'b0;
         cfg_shadow = c;

         // phase body: mostly in-rectangle draws, some loads and stray offsets
         quiet_phase = ($urandom_range(0, 3) == 0);
         burst_left  = 0;
         lim_x = int'(cfg_shadow.dest_width) - 1;
         lim_y = int'(cfg_shadow.dest_height) - 1;
         if (lim_x < 0) lim_x = 0;
         if (lim_y < 0) lim_y = 0;
         if (lim_x > 4095) lim_x = 4095;
         if (lim_y > 4095) lim_y = 4095;
         n = $urandom_range(40, 120);
         repeat (n) begin
            r.cmd       = CMD_DRAW;
            r.slot      = 12'($urandom());
            r.icon_argb = $urandom();
            r.off_x     = 12'($urandom());
            r.off_y     = 12'($urandom());
            r.dest_argb = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               r.cmd       = CMD_LOAD;
               r.icon_argb = rand_icon_pixel();
            end else if (pick < 90) begin
               r.off_x = 12'($urandom_range(0, lim_x));
               r.off_y = 12'($urandom_range(0, lim_y));
            end
            // never read an icon entry that has not been loaded
            if (r.cmd == CMD_DRAW && sprite_hit(r.off_x, r.off_y, idx, addr) &&
                !icon_loaded[idx]) begin
               ld           = r;
               ld.cmd       = CMD_LOAD;
               ld.slot      = idx;
               ld.icon_argb = rand_icon_pixel();
               pace_sender();
               send_req(ld, 1'b0, '0);
            end
            pace_sender();
            send_req(r, 1'b0, '0);
         end
         req_valid <= 1'b0;
         phase++;
      end

      while (fb_write_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS scaled_sprite_alpha_blit_unit");
      else
         $display("FAIL scaled_sprite_alpha_blit_unit");
      $finish;
   end

   // Response side: check each transfer, then pick the next ready level
   always @(posedge clock) begin : rsp_side
      fb_write_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fb_write_q.size() == 0)
            note_mismatch("unexpected transfer", 32'h0, rsp_frame_address);
         else begin
            want = fb_write_q.pop_front();
            if (rsp_write_valid !== want.wr)
               note_mismatch("write flag", want.wr, rsp_write_valid);
            if (rsp_frame_address !== want.addr)
               note_mismatch("frame address", want.addr, rsp_frame_address);
            if (rsp_blended_argb !== want.argb)
               note_mismatch("blended pixel", want.argb, rsp_blended_argb);
         end
      end

      if (mode_left == 0) begin
         drain_mode = drain_mode_t'(2'($urandom_range(0, 3)));
         mode_left  = $urandom_range(50, 300);
      end else
         mode_left--;

      case (drain_mode)
         DRAIN_FREE:   rsp_ready <= 1'b1;
         DRAIN_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         DRAIN_SPARSE: rsp_ready <= (mode_left % 4 == 0);
         default: begin
            if (hold_left == 0) begin
               rsp_ready <= !rsp_ready;
               hold_left = rsp_ready ? $urandom_range(1, 24) : $urandom_range(0, 7);
            end else
               hold_left--;
         end
      endcase
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("FAIL scaled_sprite_alpha_blit_unit");
      $finish;
   end

endmodule

// ===== scaled_sprite_alpha_blit_unit.f =====
rtl/core/ssab_pkg.sv
rtl/core/ssab_ram.sv
rtl/core/ssab_front.sv
rtl/core/ssab_queue.sv
rtl/core/ssab_back.sv
rtl/core/scaled_sprite_alpha_blit_unit.sv
test/tb.sv
